// File: rtl/core/fatigue_damage_update_defines.svh
// assertion helpers used by the checker file
`ifndef FATIGUE_DAMAGE_UPDATE_DEFINES_SVH
`define FATIGUE_DAMAGE_UPDATE_DEFINES_SVH

// implication checked only outside reset
`define FDU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fdu assertion failed");

// implication that also covers the reset cycles
`define FDU_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fdu reset assertion failed");

`endif

// File: rtl/core/fdu_pkg.sv
`default_nettype none
package fdu_pkg;

    localparam logic signed [63:0] FX_ONE      = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] FX_RECOVERY = 64'sd4294967;
    localparam logic signed [63:0] FX_QUARTER  = 64'sd1073741824;
    localparam logic signed [63:0] FX_SNAP     = 64'sd42949673;
    localparam logic signed [63:0] FX_TEN      = 64'sh0000_000A_0000_0000;
    localparam logic signed [63:0] FX_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] FX_MIN      = 64'sh8000_0000_0000_0000;

    localparam int CFG_W = 63;
    localparam logic [CFG_W-1:0] CFG_RESET = 63'h1_0000_0000;
    localparam logic [0:0] CFG_TOUGHNESS = 1'b0;
    localparam logic [0:0] CFG_TIME_STEP = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [6:0] MUL_LAST = 7'd4;
    localparam logic [6:0] DIV_LAST = 7'd95;

    typedef struct packed {
        logic signed [63:0] fatigue_in;
        logic signed [63:0] integrity_in;
        logic signed [63:0] yield_in;
        logic signed [63:0] stress;
        logic signed [63:0] endurance_limit;
        logic               snap_mode;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] fatigue_out;
        logic signed [63:0] integrity_out;
        logic signed [63:0] yield_out;
    } t_out_word;

    typedef struct packed {
        logic signed [63:0] fat;
        logic signed [63:0] integ;
        logic signed [63:0] yld;
        logic signed [63:0] stress;
        logic signed [63:0] ysum;
        logic               snap;
        logic               below;
    } t_job;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} t_state;

    typedef enum logic [2:0] {
        PH_REC, PH_RATIO, PH_R2, PH_R4, PH_DMG, PH_LOSS, PH_D10, PH_YLD
    } t_phase;

    typedef enum logic [1:0] {LN_NONE, LN_MUL, LN_DIV, LN_FIN} t_launch;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add = s[64] ? FX_MIN : FX_MAX;
        end else begin
            sat_add = s[63:0];
        end
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            sat_sub = s[64] ? FX_MIN : FX_MAX;
        end else begin
            sat_sub = s[63:0];
        end
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] s);
        mag = s[63] ? (64'd0 - s) : s;
    endfunction

    function automatic logic signed [63:0] sat_from_mag(input logic neg,
                                                        input logic hi_nz,
                                                        input logic [63:0] m);
        if (!neg) begin
            sat_from_mag = (hi_nz || m[63]) ? FX_MAX : m;
        end else begin
            sat_from_mag = (hi_nz || m[63]) ? FX_MIN : (64'd0 - m);
        end
    endfunction

    // drop 32 fraction bits, floor for negative products, then saturate
    function automatic logic signed [63:0] mul_fin(input logic neg,
                                                   input logic [127:0] acc);
        logic [96:0] t;
        t = {1'b0, acc[127:32]} + 97'(neg && (acc[31:0] != 32'd0));
        mul_fin = sat_from_mag(neg, t[96:64] != 33'd0, t[63:0]);
    endfunction

    function automatic logic signed [63:0] div_fin(input logic neg,
                                                   input logic [95:0] q);
        div_fin = sat_from_mag(neg, q[95:64] != 32'd0, q[63:0]);
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/fdu_if.sv
`default_nettype none
interface fdu_in_if;
    import fdu_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fdu_out_if;
    import fdu_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fdu_front.sv
`default_nettype none
module fdu_front (
    fdu_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output fdu_pkg::t_job o_job
);
    import fdu_pkg::*;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_job.fat    = i_in.data.fatigue_in;
        o_job.integ  = i_in.data.integrity_in;
        o_job.yld    = i_in.data.yield_in;
        o_job.stress = i_in.data.stress;
        // divisor is yield plus one lsb, saturating
        o_job.ysum   = sat_add(i_in.data.yield_in, 64'sd1);
        o_job.snap   = i_in.data.snap_mode;
        o_job.below  = $signed(i_in.data.stress) <= $signed(i_in.data.endurance_limit);
    end
endmodule
`default_nettype wire

// File: rtl/core/fdu_queue.sv
`default_nettype none
module fdu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fdu_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output fdu_pkg::t_job o_job,
    input  logic          i_pop
);
    import fdu_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp + QAW'(i_push);
        n_rp  = r_rp + QAW'(i_pop);
        n_cnt = r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/fdu_back.sv
`default_nettype none
module fdu_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  fdu_pkg::t_job               i_job,
    output logic                        o_job_pop,
    input  logic [fdu_pkg::CFG_W-1:0]   i_toughness,
    input  logic [fdu_pkg::CFG_W-1:0]   i_time_step,
    fdu_out_if.source                   o_out
);
    import fdu_pkg::*;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    t_job               r_job, n_job;
    logic signed [63:0] r_dmg, n_dmg;
    logic [63:0]        r_ma, n_ma;
    logic [63:0]        r_mb, n_mb;
    logic               r_neg, n_neg;
    logic [6:0]         r_cnt, n_cnt;
    logic [63:0]        r_pp, n_pp;
    logic [127:0]       r_acc, n_acc;
    logic [95:0]        r_dvd, n_dvd;
    logic [95:0]        r_q, n_q;
    logic [63:0]        r_rem, n_rem;
    logic               r_dz, n_dz;
    logic signed [63:0] r_dzres, n_dzres;
    logic               r_ovalid, n_ovalid;
    t_out_word          r_odata, n_odata;

    logic signed [63:0] tough, dt;
    logic [31:0]        a_part, b_part;
    logic [63:0]        pp_nx;
    logic [127:0]       pp_sh, acc_nx;
    logic [63:0]        rem_s, rem_nx;
    logic               ge;
    logic [95:0]        q_nx;
    logic               u_done;
    logic signed [63:0] u_res;
    t_launch            ln;
    logic signed [63:0] ln_a, ln_b;
    t_phase             ln_phase;
    t_job               post_job;
    logic signed [63:0] post_dmg;
    logic               slot_free;

    assign tough     = $signed({1'b0, i_toughness});
    assign dt        = $signed({1'b0, i_time_step});
    assign slot_free = !r_ovalid || o_out.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // shared 64x64 multiplier: four 32x32 partial products, one per cycle
    always_comb begin
        a_part = (r_cnt == 7'd0 || r_cnt == 7'd1) ? r_ma[31:0] : r_ma[63:32];
        b_part = (r_cnt == 7'd0 || r_cnt == 7'd2) ? r_mb[31:0] : r_mb[63:32];
        pp_nx  = a_part * b_part;
        if (r_cnt == 7'd1) begin
            pp_sh = {64'd0, r_pp};
        end else if (r_cnt == MUL_LAST) begin
            pp_sh = {r_pp, 64'd0};
        end else begin
            pp_sh = {32'd0, r_pp, 32'd0};
        end
        acc_nx = r_acc + ((r_cnt == 7'd0) ? 128'd0 : pp_sh);
    end

    // shared restoring divider, one quotient bit per cycle
    always_comb begin
        rem_s  = {r_rem[62:0], r_dvd[95]};
        ge     = rem_s >= r_mb;
        rem_nx = ge ? (rem_s - r_mb) : rem_s;
        q_nx   = {r_q[94:0], ge};
    end

    always_comb begin
        u_done = ((r_state == ST_MUL) && (r_cnt == MUL_LAST)) ||
                 ((r_state == ST_DIV) && (r_dz || (r_cnt == DIV_LAST)));
        if (r_state == ST_MUL) begin
            u_res = mul_fin(r_neg, acc_nx);
        end else if (r_dz) begin
            u_res = r_dzres;
        end else begin
            u_res = div_fin(r_neg, q_nx);
        end
    end

    // sequencer: fold in the finished operation and pick the next one
    always_comb begin
        logic signed [63:0] f;
        ln       = LN_NONE;
        ln_a     = '0;
        ln_b     = '0;
        ln_phase = r_phase;
        post_job = r_job;
        post_dmg = r_dmg;
        f        = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    post_job = i_job;
                    if (i_job.below) begin
                        ln = LN_MUL; ln_a = FX_RECOVERY; ln_b = dt; ln_phase = PH_REC;
                    end else begin
                        ln = LN_DIV; ln_a = i_job.stress; ln_b = i_job.ysum;
                        ln_phase = PH_RATIO;
                    end
                end
            end
            ST_MUL, ST_DIV: begin
                if (u_done) begin
                    case (r_phase)
                        PH_REC: begin
                            f = sat_sub(r_job.fat, u_res);
                            post_job.fat = f[63] ? 64'sd0 : f;
                            ln = LN_FIN;
                        end
                        PH_RATIO: begin
                            ln = LN_MUL; ln_a = u_res; ln_b = u_res; ln_phase = PH_R2;
                        end
                        PH_R2: begin
                            ln = LN_MUL; ln_a = u_res; ln_b = u_res; ln_phase = PH_R4;
                        end
                        PH_R4: begin
                            ln = LN_MUL; ln_a = u_res; ln_b = dt; ln_phase = PH_DMG;
                        end
                        PH_DMG: begin
                            post_dmg = u_res;
                            f = sat_add(r_job.fat, u_res);
                            post_job.fat = f;
                            ln = LN_DIV; ln_a = f; ln_b = tough; ln_phase = PH_LOSS;
                        end
                        PH_LOSS: begin
                            post_job.integ = (u_res < FX_ONE) ? sat_sub(FX_ONE, u_res) : 64'sd0;
                            ln = LN_MUL; ln_a = r_dmg; ln_b = FX_TEN; ln_phase = PH_D10;
                        end
                        PH_D10: begin
                            ln = LN_MUL; ln_a = r_job.yld; ln_b = sat_sub(FX_ONE, u_res);
                            ln_phase = PH_YLD;
                        end
                        PH_YLD: begin
                            post_job.yld = u_res;
                            // snap low integrity to near failure
                            if (r_job.snap && (r_job.integ < FX_QUARTER) &&
                                (r_job.integ > 64'sd0)) begin
                                post_job.integ = FX_SNAP;
                                post_job.fat   = tough;
                            end
                            ln = LN_FIN;
                        end
                        default: ln = LN_FIN;
                    endcase
                end
            end
            default: ln = LN_NONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_MUL, ST_DIV: begin
                case (ln)
                    LN_MUL:  n_state = ST_MUL;
                    LN_DIV:  n_state = ST_DIV;
                    LN_FIN:  n_state = ST_FIN;
                    default: n_state = r_state;
                endcase
            end
            ST_FIN: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_job    = post_job;
        n_dmg    = post_dmg;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_pp     = r_pp;
        n_acc    = r_acc;
        n_dvd    = r_dvd;
        n_q      = r_q;
        n_rem    = r_rem;
        n_dz     = r_dz;
        n_dzres  = r_dzres;
        n_ovalid = r_ovalid && !o_out.ready;
        n_odata  = r_odata;
        o_job_pop = (r_state == ST_IDLE) && i_job_valid;

        if (ln == LN_MUL) begin
            n_phase = ln_phase;
            n_ma    = mag(ln_a);
            n_mb    = mag(ln_b);
            n_neg   = ln_a[63] ^ ln_b[63];
            n_cnt   = '0;
            n_acc   = '0;
        end else if (ln == LN_DIV) begin
            n_phase = ln_phase;
            n_mb    = mag(ln_b);
            n_neg   = ln_a[63] ^ ln_b[63];
            n_dvd   = {mag(ln_a), 32'd0};
            n_q     = '0;
            n_rem   = '0;
            n_cnt   = '0;
            n_dz    = (ln_b == 64'sd0);
            n_dzres = ln_a[63] ? FX_MIN : FX_MAX;
        end else if (r_state == ST_MUL) begin
            n_cnt = r_cnt + 7'd1;
            n_pp  = pp_nx;
            n_acc = acc_nx;
        end else if (r_state == ST_DIV) begin
            n_cnt = r_cnt + 7'd1;
            n_rem = rem_nx;
            n_q   = q_nx;
            n_dvd = {r_dvd[94:0], 1'b0};
        end

        if ((r_state == ST_FIN) && slot_free) begin
            n_ovalid = 1'b1;
            n_odata.fatigue_out   = r_job.fat;
            n_odata.integrity_out = r_job.integ;
            n_odata.yield_out     = r_job.yld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_job   <= n_job;
        r_dmg   <= n_dmg;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_pp    <= n_pp;
        r_acc   <= n_acc;
        r_dvd   <= n_dvd;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_dz    <= n_dz;
        r_dzres <= n_dzres;
        r_odata <= n_odata;
    end
endmodule
`default_nettype wire

// File: rtl/core/fatigue_damage_update.sv
// channel  dir  handshake     word
// i_in     in   valid/ready   fatigue, integrity, yield, stress, endurance, snap
// o_out    out  valid/ready   fatigue, integrity, yield
// i_cfg    in   write enable  toughness (0), time step (1)
//
// a four-word queue takes one word per cycle, unless full, while the back end works
// below endurance a word needs one 64x64 multiply in the back end
// above it two 96-step divides and five multiplies, all run
// on the one shared divider and multiplier
// synchronous reset empties the queue and output register; both config registers return to 1.0
// a stalled output holds its word and the back end waits before handing over the next one
`default_nettype none
module fatigue_damage_update (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_idx,
    input  logic [fdu_pkg::CFG_W-1:0] i_cfg_data,
    fdu_in_if.sink                    i_in,
    fdu_out_if.source                 o_out
);
    import fdu_pkg::*;

    logic [CFG_W-1:0] r_toughness, r_time_step;
    logic             push, q_full, q_valid, q_pop;
    t_job             push_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toughness <= CFG_RESET;
            r_time_step <= CFG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TOUGHNESS) begin
                r_toughness <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_TIME_STEP) begin
                r_time_step <= i_cfg_data;
            end
        end
    end

    fdu_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    fdu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    fdu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .i_toughness (r_toughness),
        .i_time_step (r_time_step),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

// File: rtl/core/fdu_checker.sv
`default_nettype none
`include "fatigue_damage_update_defines.svh"
module fdu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input fdu_pkg::t_out_word i_out_data
);
    `FDU_ASSERT_RST(a_no_word_after_reset, i_clk, !i_rst_n, !i_out_valid)
    `FDU_ASSERT_RST(a_ready_after_reset, i_clk, !i_rst_n, i_in_ready)
    `FDU_ASSERT_IMP(a_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `FDU_ASSERT_IMP(a_word_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data))
endmodule

bind fatigue_damage_update fdu_checker u_fdu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire
